// File: hw/rtl/ubsd_pkg.sv
// ----------------------------------------------------------------------------
// ubsd_pkg: shared types and constants of the UTF-8 byte stream decoder
// Result and queue entry layouts, field widths and the queue geometry.
// ----------------------------------------------------------------------------
package ubsd_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned WIDTH_W  = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // Question mark, the error code point after reset.
    localparam logic [CP_W-1:0] ERR_CP_RESET = CP_W'(8'h3F);

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [WIDTH_W-1:0] width;
        logic               err;
    } result_t;

    // Everything one input byte produces: one result, or two.
    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hw/rtl/ubsd_front.sv
// ----------------------------------------------------------------------------
// ubsd_front: byte intake and sequence state machine
// Accepts one byte per cycle while the queue has room, tracks the character in
// progress and writes the results each byte causes into the queue as one entry.
// ----------------------------------------------------------------------------
module ubsd_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ubsd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         end_of_buffer,
    input  logic [ubsd_pkg::CP_W-1:0]    err_cp,
    input  ubsd_pkg::q_status_t          q_status,
    output logic                         push,
    output ubsd_pkg::entry_t             push_entry
);
    import ubsd_pkg::*;

    typedef enum logic [1:0]
    {
        PH_IDLE    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2,
        PH_STOP    = 2'd3
    } phase_t;

    typedef struct packed {
        logic               emit;
        result_t            res;
        phase_t             nphase;
        logic [1:0]         nneed;
        logic [CP_W-1:0]    nacc;
        logic [WIDTH_W-1:0] nwidth;
    } start_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         need_reg, need_next;
    logic [CP_W-1:0]    acc_reg, acc_next;
    logic [WIDTH_W-1:0] width_reg, width_next;

    logic               accept;
    logic [CP_W-1:0]    acc_shift;
    logic [WIDTH_W-1:0] width_inc;
    start_t             start_res;

    function automatic logic [WIDTH_W-1:0] sat_inc(input logic [WIDTH_W-1:0] x);
        return (x == {WIDTH_W{1'b1}}) ? x : x + WIDTH_W'(1);
    endfunction

    // Handle a byte where a character starts, fresh or after strays.
    function automatic start_t char_start
    (
        input logic [BYTE_W-1:0]  b,
        input logic               eob,
        input logic               fresh,
        input logic [WIDTH_W-1:0] w,
        input logic [CP_W-1:0]    ecp
    );
        start_t     r;
        logic       lead_ok;
        logic [1:0] need;
        logic [4:0] bits;
        r.emit      = 1'b0;
        r.res.cp    = ecp;
        r.res.width = w;
        r.res.err   = 1'b1;
        r.nphase    = PH_IDLE;
        r.nneed     = 2'd0;
        r.nacc      = '0;
        r.nwidth    = WIDTH_W'(1);
        lead_ok     = 1'b1;
        need        = 2'd0;
        bits        = 5'd0;
        if (fresh && b == '0)
        begin
            r.nphase = eob ? PH_IDLE : PH_STOP;
        end
        else if (b[7:6] == 2'b10)
        begin
            if (eob)
            begin
                r.emit = 1'b1;
            end
            else
            begin
                r.nwidth = sat_inc(w);
                r.nphase = PH_SKIP;
            end
        end
        else if (!b[7])
        begin
            r.emit    = 1'b1;
            r.res.cp  = CP_W'(b);
            r.res.err = 1'b0;
        end
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                need = 2'd1;
                bits = b[4:0];
            end
            else if (b[7:4] == 4'b1110)
            begin
                need = 2'd2;
                bits = {1'b0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                need = 2'd3;
                bits = {2'b00, b[2:0]};
            end
            else
            begin
                lead_ok = 1'b0;
            end
            if (!lead_ok || eob)
            begin
                r.emit = 1'b1;
            end
            else
            begin
                r.nacc   = CP_W'(bits);
                r.nneed  = need;
                r.nphase = PH_COLLECT;
                r.nwidth = w;
            end
        end
        return r;
    endfunction

    assign in_stall  = q_status.full;
    assign accept    = in_valid && !in_stall;
    assign acc_shift = {acc_reg[CP_W-7:0], data_byte[5:0]};
    assign width_inc = sat_inc(width_reg);

    // A mid-sequence non-continuation restarts from a fresh idle state.
    assign start_res = (phase_reg == PH_COLLECT)
                     ? char_start(data_byte, end_of_buffer, 1'b1, WIDTH_W'(1), err_cp)
                     : char_start(data_byte, end_of_buffer, phase_reg == PH_IDLE,
                                  width_reg, err_cp);

    always_comb
    begin
        phase_next       = phase_reg;
        need_next        = need_reg;
        acc_next         = acc_reg;
        width_next       = width_reg;
        push             = 1'b0;
        push_entry.res0  = start_res.res;
        push_entry.res1  = start_res.res;
        push_entry.two   = 1'b0;
        unique case (phase_reg) inside
            PH_STOP:
            begin
                if (end_of_buffer)
                begin
                    phase_next = PH_IDLE;
                    need_next  = 2'd0;
                    acc_next   = '0;
                    width_next = WIDTH_W'(1);
                end
            end
            PH_IDLE, PH_SKIP:
            begin
                push       = start_res.emit;
                phase_next = start_res.nphase;
                need_next  = start_res.nneed;
                acc_next   = start_res.nacc;
                width_next = start_res.nwidth;
            end
            PH_COLLECT:
            begin
                if (data_byte[7:6] == 2'b10)
                begin
                    push                  = (need_reg <= 2'd1) || end_of_buffer;
                    push_entry.res0.cp    = (need_reg <= 2'd1) ? acc_shift : err_cp;
                    push_entry.res0.width = width_inc;
                    push_entry.res0.err   = (need_reg > 2'd1);
                    if (push)
                    begin
                        phase_next = PH_IDLE;
                        need_next  = 2'd0;
                        acc_next   = '0;
                        width_next = WIDTH_W'(1);
                    end
                    else
                    begin
                        need_next  = need_reg - 2'd1;
                        acc_next   = acc_shift;
                        width_next = width_inc;
                    end
                end
                else
                begin
                    // Error for the broken sequence, then the byte starts anew.
                    push                  = 1'b1;
                    push_entry.res0.cp    = err_cp;
                    push_entry.res0.width = width_reg;
                    push_entry.res0.err   = 1'b1;
                    push_entry.two        = start_res.emit;
                    phase_next            = start_res.nphase;
                    need_next             = start_res.nneed;
                    acc_next              = start_res.nacc;
                    width_next            = start_res.nwidth;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (!accept)
        begin
            push       = 1'b0;
            phase_next = phase_reg;
            need_next  = need_reg;
            acc_next   = acc_reg;
            width_next = width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            need_reg  <= 2'd0;
            acc_reg   <= '0;
            width_reg <= WIDTH_W'(1);
        end
        else
        begin
            phase_reg <= phase_next;
            need_reg  <= need_next;
            acc_reg   <= acc_next;
            width_reg <= width_next;
        end
    end

endmodule

// File: hw/rtl/ubsd_queue.sv
// ----------------------------------------------------------------------------
// ubsd_queue: entry queue between intake and output
// Small FIFO of per-byte entries so each side can stall on its own.
// ----------------------------------------------------------------------------
module ubsd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ubsd_pkg::entry_t    push_entry,
    input  logic                pop,
    output ubsd_pkg::entry_t    pop_entry,
    output ubsd_pkg::q_status_t q_status
);
    import ubsd_pkg::*;

    entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_entry      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/ubsd_back.sv
// ----------------------------------------------------------------------------
// ubsd_back: result output stage
// Holds one queue entry and delivers its one or two results in order.
// ----------------------------------------------------------------------------
module ubsd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ubsd_pkg::entry_t            pop_entry,
    input  ubsd_pkg::q_status_t         q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ubsd_pkg::CP_W-1:0]   code_point,
    output logic [ubsd_pkg::WIDTH_W-1:0] byte_width,
    output logic                        is_error,
    output logic                        last_of_item
);
    import ubsd_pkg::*;

    entry_t  cur_reg, cur_next;
    logic    valid_reg, valid_next;
    logic    second_reg, second_next;
    logic    accept;
    logic    done;
    logic    load;
    result_t res;

    assign accept = valid_reg && !out_stall;
    assign done   = accept && (second_reg || !cur_reg.two);
    assign load   = !valid_reg || done;
    assign pop    = load && !q_status.empty;

    always_comb
    begin
        cur_next    = cur_reg;
        valid_next  = valid_reg;
        second_next = second_reg;
        if (load)
        begin
            cur_next    = pop_entry;
            valid_next  = !q_status.empty;
            second_next = 1'b0;
        end
        else if (accept)
        begin
            second_next = 1'b1;
        end
    end

    assign res          = second_reg ? cur_reg.res1 : cur_reg.res0;
    assign out_valid    = valid_reg;
    assign code_point   = res.cp;
    assign byte_width   = res.width;
    assign is_error     = res.err;
    assign last_of_item = second_reg || !cur_reg.two;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: hw/rtl/utf8_byte_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit: UTF-8 byte stream to code point decoder
// Decodes a UTF-8 byte stream into code points with their byte widths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one byte per transfer, with
//   end_of_buffer set on the last byte of a buffer. A byte can be taken
//   every cycle while the entry queue has room.
//   Output channel (out_valid / out_stall): one result per transfer:
//   code_point, byte_width, is_error, and last_of_item on the final result
//   of its byte. A byte causes zero, one or two results.
//   Config channel (cfg_valid / cfg_ready): cfg_data sets the code point
//   emitted for malformed input; write it only while the block is idle.
//   Throughput: one byte per cycle while the queue has room, one result
//   per cycle while out_stall is low; a byte giving two results holds the
//   output stage for both, absorbed by the four-entry queue between the
//   intake and the output stage.
//   Reset: the decoder waits for a lead byte, queue and output are empty
//   and the error code point is the question mark.
//   Receiver stall: the output holds its result; the queue fills and then
//   in_stall rises until space frees up.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ubsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          end_of_buffer,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ubsd_pkg::CP_W-1:0]     code_point,
    output logic [ubsd_pkg::WIDTH_W-1:0]  byte_width,
    output logic                          is_error,
    output logic                          last_of_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ubsd_pkg::CP_W-1:0]     cfg_data
);
    import ubsd_pkg::*;

    logic [CP_W-1:0] error_code_point_reg, error_code_point_next;
    logic            push;
    logic            pop;
    entry_t          push_entry;
    entry_t          pop_entry;
    q_status_t       q_status;

    // The config register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        error_code_point_next = error_code_point_reg;
        if (cfg_valid && cfg_ready)
        begin
            error_code_point_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_code_point_reg <= ERR_CP_RESET;
        end
        else
        begin
            error_code_point_reg <= error_code_point_next;
        end
    end

    // Classify each byte and queue the results it causes.
    ubsd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .err_cp        (error_code_point_reg),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Decouple intake from delivery.
    ubsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    // Deliver results one per transfer, in order.
    ubsd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_entry    (pop_entry),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .byte_width   (byte_width),
        .is_error     (is_error),
        .last_of_item (last_of_item)
    );

endmodule

// File: tb/utf8_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decode_checker: result predictor and scoreboard for the UTF-8 decoder
// Watches the byte, result and config channels, decodes every accepted byte
// on its own and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_decode_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [ubsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          end_of_buffer,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ubsd_pkg::CP_W-1:0]     code_point,
    input  logic [ubsd_pkg::WIDTH_W-1:0]  byte_width,
    input  logic                          is_error,
    input  logic                          last_of_item,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ubsd_pkg::CP_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending_count,
    output int                            chars_checked,
    output int                            error_chars
);
    import ubsd_pkg::*;

    typedef enum logic [1:0] {AWAIT_LEAD, SKIP_STRAYS, COLLECT, STOPPED} decode_phase_t;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [WIDTH_W-1:0] width;
        logic               err;
        logic               last;
    } char_t;

    decode_phase_t      phase;
    logic [1:0]         conts_left;
    logic [CP_W-1:0]    acc;
    logic [WIDTH_W-1:0] width_so_far;
    logic [CP_W-1:0]    err_cp;

    char_t byte_chars [2];
    int    byte_char_count;
    char_t expected_chars [$];
    char_t oldest;

    function automatic logic [WIDTH_W-1:0] bump_width(input logic [WIDTH_W-1:0] w);
        return (w == '1) ? w : w + 1'b1;
    endfunction

    task automatic note_char(input logic [CP_W-1:0] cp, input logic [WIDTH_W-1:0] w,
                             input logic err);
        if (byte_char_count < 2)
        begin
            byte_chars[byte_char_count] = '{cp: cp, width: w, err: err, last: 1'b0};
            byte_char_count++;
        end
    endtask

    task automatic restart_char();
        phase        = AWAIT_LEAD;
        conts_left   = '0;
        acc          = '0;
        width_so_far = WIDTH_W'(1);
    endtask

    // A byte where a character begins; fresh is low after skipped strays.
    task automatic start_char(input logic [BYTE_W-1:0] b, input logic eob, input logic fresh);
        logic [WIDTH_W-1:0] w;
        w = width_so_far;
        if (fresh && b == '0)
        begin
            restart_char();
            if (!eob)
                phase = STOPPED;
        end
        else if (b[7:6] == 2'b10)
        begin
            if (eob)
            begin
                note_char(err_cp, w, 1'b1);
                restart_char();
            end
            else
            begin
                width_so_far = bump_width(width_so_far);
                phase        = SKIP_STRAYS;
            end
        end
        else if (!b[7])
        begin
            note_char(CP_W'(b), w, 1'b0);
            restart_char();
        end
        else if (b[7:3] == 5'b11111 || eob)
        begin
            note_char(err_cp, w, 1'b1);
            restart_char();
        end
        else
        begin
            if (!b[5])
            begin
                acc        = CP_W'(b[4:0]);
                conts_left = 2'd1;
            end
            else if (!b[4])
            begin
                acc        = CP_W'(b[3:0]);
                conts_left = 2'd2;
            end
            else
            begin
                acc        = CP_W'(b[2:0]);
                conts_left = 2'd3;
            end
            phase = COLLECT;
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eob);
        byte_char_count = 0;
        case (phase)
            STOPPED:
                if (eob)
                    restart_char();
            AWAIT_LEAD:
                start_char(b, eob, 1'b1);
            SKIP_STRAYS:
                start_char(b, eob, 1'b0);
            default:
                if (b[7:6] == 2'b10)
                begin
                    acc          = {acc[CP_W-7:0], b[5:0]};
                    width_so_far = bump_width(width_so_far);
                    if (conts_left <= 2'd1)
                    begin
                        note_char(acc, width_so_far, 1'b0);
                        restart_char();
                    end
                    else if (eob)
                    begin
                        note_char(err_cp, width_so_far, 1'b1);
                        restart_char();
                    end
                    else
                        conts_left = conts_left - 2'd1;
                end
                else
                begin
                    // drop the broken sequence, then retry the byte as a new lead
                    note_char(err_cp, width_so_far, 1'b1);
                    restart_char();
                    start_char(b, eob, 1'b1);
                end
        endcase
        for (int i = 0; i < byte_char_count; i++)
        begin
            byte_chars[i].last = (i == byte_char_count - 1);
            expected_chars     = {expected_chars, byte_chars[i]};
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_cp = ERR_CP_RESET;
            restart_char();
            expected_chars.delete();
            fail_count    = 0;
            chars_checked = 0;
            error_chars   = 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none expected: expected nothing, got cp %0h",
                             $time, code_point);
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    check_field("code_point", 32'(oldest.cp), 32'(code_point));
                    check_field("byte_width", 32'(oldest.width), 32'(byte_width));
                    check_field("is_error", 32'(oldest.err), 32'(is_error));
                    check_field("last_of_item", 32'(oldest.last), 32'(last_of_item));
                    chars_checked++;
                    if (oldest.err)
                        error_chars++;
                end
            end
            if (in_valid && !in_stall)
                decode_byte(data_byte, end_of_buffer);
            // a byte taken at the same edge still sees the old error code point
            if (cfg_valid && cfg_ready)
                err_cp = cfg_data;
            pending_count <= expected_chars.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the UTF-8 byte stream decoder
// Feeds directed and random byte streams under changing idle patterns and
// error code points; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;

    import ubsd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 200;  // long receiver hold-off, fills the queue
    localparam int SETTLE_CYCLES  = 8;    // margin for results still in the queue or output stage
    localparam int WATCHDOG_LIMIT = 3000; // quiet cycles before giving up
    localparam int STRAY_RUN      = 300;  // enough strays to saturate byte_width

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  data_byte;
    logic               end_of_buffer;
    logic               out_valid;
    logic               out_stall;
    logic [CP_W-1:0]    code_point;
    logic [WIDTH_W-1:0] byte_width;
    logic               is_error;
    logic               last_of_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CP_W-1:0]    cfg_data;

    int fail_count;
    int pending_count;
    int chars_checked;
    int error_chars;

    // Idle rates in percent; changed only at a rising edge while drained.
    int   send_idle_pct  = 19;
    int   recv_stall_pct = 59;
    logic hold_request;
    int   bytes_sent;
    int   idle_run;
    logic [CP_W-1:0] random_err_cp;

    utf8_byte_stream_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .byte_width    (byte_width),
        .is_error      (is_error),
        .last_of_item  (last_of_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    utf8_decode_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .byte_width    (byte_width),
        .is_error      (is_error),
        .last_of_item  (last_of_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .chars_checked (chars_checked),
        .error_chars   (error_chars)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: stall at random on each falling edge. When a hold-off is
    // requested, keep stall high for a long stretch so the queue fills and
    // the block pushes back on its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall    = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_count);
        $display("** utf8_byte_stream_decoder_unit: FAILED **");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | BYTE_W'($urandom_range(0, 63));
    endfunction

    function automatic logic rand_eob();
        return ($urandom_range(0, 24) == 0);
    endfunction

    // Offer one byte on the falling edge, idling first at random, and hold
    // it until the transfer happens. Valid stays high for the next byte.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic eob);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        data_byte     = value;
        end_of_buffer = eob;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // One random character: mostly well-formed leads with their
    // continuation bytes, some with leading strays, some cut short, bad
    // leads, arbitrary bytes and string stops.
    task automatic send_random_char();
        int kind;
        int conts;
        logic [BYTE_W-1:0] lead;
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 3)) send_byte(cont_byte(), rand_eob());
        kind  = $urandom_range(0, 99);
        conts = 0;
        if (kind < 28)
            lead = BYTE_W'($urandom_range(1, 127));
        else if (kind < 46)
        begin
            lead  = 8'hC0 | BYTE_W'($urandom_range(0, 31));
            conts = 1;
        end
        else if (kind < 62)
        begin
            lead  = 8'hE0 | BYTE_W'($urandom_range(0, 15));
            conts = 2;
        end
        else if (kind < 78)
        begin
            lead  = 8'hF0 | BYTE_W'($urandom_range(0, 7));
            conts = 3;
        end
        else if (kind < 86)
            lead = BYTE_W'($urandom_range(248, 255));
        else if (kind < 95)
            lead = BYTE_W'($urandom_range(0, 255));
        else
            lead = 8'h00;
        // cut some multi-byte sequences short so the next lead breaks them
        if (conts > 0 && $urandom_range(0, 99) < 15)
            conts = $urandom_range(0, conts - 1);
        send_byte(lead, rand_eob());
        repeat (conts) send_byte(cont_byte(), rand_eob());
        if (lead == 8'h00 && kind >= 95)
        begin
            // bytes after a string stop are ignored up to the buffer end
            repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Close the buffer, drop valid and wait until every predicted result
    // has been transferred, plus SETTLE_CYCLES more for work still in flight.
    task automatic drain();
        send_byte(8'h2E, 1'b1);
        @(negedge clk);
        in_valid = 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_error_cp(input logic [CP_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int byte_target);
        while (bytes_sent < byte_target)
            send_random_char();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_buffer = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part, with the error code point at its reset value.
        send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);                 // two-byte form
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);                 // largest four-byte
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);                 // stray, then ASCII
        send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);                 // bad leads
        send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);                 // broken: two results
        send_byte(8'hC3, 1'b1);                                         // buffer end after lead
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);                 // buffer end mid-way
        send_byte(8'h80, 1'b1);                                         // buffer end on stray
        send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);                 // zero after a stray
        send_byte(8'h00, 1'b0); send_byte(8'h41, 1'b0);                 // string stop, ignore
        send_byte(8'h42, 1'b1);
        send_byte(8'h7F, 1'b0);
        drain();

        // Sender idles a little, receiver a lot; error code point at zero.
        write_error_cp('0);
        random_phase(120);
        drain();

        // Swap the idle rates; error code point at its maximum.
        send_idle_pct  = 59;
        recv_stall_pct = 19;
        write_error_cp('1);
        random_phase(185);
        drain();

        // No idling at all, apart from one long hold-off of the receiver.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        random_err_cp  = CP_W'($urandom_range(0, 2097151));
        write_error_cp(random_err_cp);
        random_phase(250);
        // Saturate the width with a long run of strays before a sequence.
        send_byte(8'h41, 1'b1);
        repeat (STRAY_RUN) send_byte(cont_byte(), 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        drain();

        $display("Run covered %0d bytes under three idle patterns and a long output hold-off;",
                 bytes_sent);
        $display("%0d results checked (%0d malformed), error code point 3F, 0, 1FFFFF, %0h.",
                 chars_checked, error_chars, random_err_cp);
        if (fail_count == 0 && pending_count == 0)
            $display("** utf8_byte_stream_decoder_unit: PASSED **");
        else
            $display("** utf8_byte_stream_decoder_unit: FAILED **");
        $finish;
    end

endmodule
